// ----- src/spo_pkg.sv -----
// ----------------------------------------------------------------------------
// spo_pkg
// Shared types, constants and helpers of the septet/octet packer.
// ----------------------------------------------------------------------------
package spo_pkg;

   localparam int DATA_W      = 8;
   localparam int SPARE_W     = 3;
   localparam int SEPTET_W    = 7;
   localparam int OCTET_W     = 8;
   localparam int STORE_W     = 14;
   localparam int COUNT_W     = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic MODE_PACK   = 1'b0;
   localparam logic MODE_UNPACK = 1'b1;

   // one result beat
   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic               has;
      logic               last;
      logic [SPARE_W-1:0] spare;
   } spo_beat_type;

   // all beats caused by one accepted item
   typedef struct packed {
      logic         two;
      spo_beat_type beat0;
      spo_beat_type beat1;
   } spo_job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } spo_q_status_type;

   function automatic logic [OCTET_W-1:0] rev8(input logic [OCTET_W-1:0] v);
      logic [OCTET_W-1:0] r;
      for (int i = 0; i < OCTET_W; i++) begin
         r[i] = v[OCTET_W-1-i];
      end
      return r;
   endfunction

endpackage

// ----- src/spo_req_if.sv -----
// ----------------------------------------------------------------------------
// spo_req_if
// Input channel: one septet or octet per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spo_req_if
   import spo_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  data_in;
   logic               last_in;
   logic [SPARE_W-1:0] spare_in;

   modport source (output valid, data_in, last_in, spare_in, input ready);
   modport sink   (input valid, data_in, last_in, spare_in, output ready);
endinterface

// ----- src/spo_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spo_rsp_if
// Result channel: one octet or septet per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spo_rsp_if
   import spo_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  data_out;
   logic               has_data;
   logic               last_out;
   logic [SPARE_W-1:0] spare_out;

   modport source (output valid, data_out, has_data, last_out, spare_out, input ready);
   modport sink   (input valid, data_out, has_data, last_out, spare_out, output ready);
endinterface

// ----- src/septet_octet_packer_core.sv -----
// ----------------------------------------------------------------------------
// septet_octet_packer_core
// Converts between 7-bit septets and bit-reversed octets.
// ----------------------------------------------------------------------------
// Usage:
//   csr_write_en / csr_write_data set the direction (0 pack, 1 unpack) and
//   clear the bit accumulator. Write only while the block is idle.
//   req carries one beat per element: data_in, last_in (end of a name) and
//   spare_in (padding bits of the final octet, unpack only).
//   rsp carries the produced beats: data_out, has_data (0 on an empty
//   closing beat), last_out and spare_out (pack padding on the last beat).
// Path: the beats of an item pass the job queue, then the output register.
// Throughput: one item per cycle while the job queue is not full. An item
//   yields zero, one or two beats; the result side drains one beat per
//   cycle while rsp is ready; the job queue (QUEUE_DEPTH jobs) absorbs them.
// Reset: synchronous; selects pack mode, empties accumulator and queue.
// Stall: when rsp is held off, the output register holds its beat and the
//   queue fills; req.ready drops only once the queue is full.
// ----------------------------------------------------------------------------
module septet_octet_packer_core
   import spo_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_write_en,
   input  logic     csr_write_data,
   spo_req_if.sink  req,
   spo_rsp_if.source rsp
);

   spo_q_status_type q_status;
   spo_job_type      push_job;
   spo_job_type      head_job;
   logic             push;
   logic             pop;

   // front: accumulate bits, form the beats of each item
   spo_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req            (req),
      .q_status       (q_status),
      .push           (push),
      .push_job       (push_job)
   );

   // hold jobs so either side can stall on its own
   spo_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // back: drain one beat per cycle into the output register while it is free
   spo_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

// ----- src/spo_front.sv -----
// ----------------------------------------------------------------------------
// spo_front
// Accepts items, runs the bit accumulator and forms the beats of each item.
// ----------------------------------------------------------------------------
module spo_front
   import spo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic             csr_write_data,
   spo_req_if.sink          req,
   input  spo_q_status_type q_status,
   output logic             push,
   output spo_job_type      push_job
);

   logic               mode_ff, mode_in;
   logic [STORE_W-1:0] store_ff, store_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               accept;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      logic [STORE_W-1:0] sum;
      logic [COUNT_W-1:0] cnt;
      logic [COUNT_W-1:0] avail;
      logic [1:0]         n;
      spo_beat_type       b0, b1, part, empty_b;

      sum     = '0;
      cnt     = '0;
      avail   = '0;
      n       = 2'd0;
      b0      = '0;
      b1      = '0;
      part    = '0;
      empty_b = '0;
      empty_b.last = 1'b1;

      if (mode_ff == MODE_PACK) begin
         sum = store_ff | (STORE_W'(req.data_in[SEPTET_W-1:0]) << count_ff);
         cnt = count_ff + COUNT_W'(SEPTET_W);
         if (cnt >= COUNT_W'(OCTET_W)) begin
            b0.data = rev8(sum[OCTET_W-1:0]);
            b0.has  = 1'b1;
            sum     = sum >> OCTET_W;
            cnt     = cnt - COUNT_W'(OCTET_W);
            n       = 2'd1;
         end
         if (req.last_in) begin
            if (cnt != '0) begin
               // flush the zero-padded partial octet
               part.data  = rev8(sum[OCTET_W-1:0]);
               part.has   = 1'b1;
               part.last  = 1'b1;
               part.spare = SPARE_W'(COUNT_W'(OCTET_W) - cnt);
               if (n == 2'd0) begin
                  b0 = part;
               end else begin
                  b1 = part;
               end
               n = n + 2'd1;
            end else if (n == 2'd1) begin
               b0.last = 1'b1;
            end else begin
               b0 = empty_b;
               n  = 2'd1;
            end
            sum = '0;
            cnt = '0;
         end
      end else begin
         sum = store_ff | (STORE_W'(rev8(req.data_in)) << count_ff);
         cnt = count_ff + COUNT_W'(OCTET_W);
         if (req.last_in) begin
            avail = (COUNT_W'(req.spare_in) <= cnt) ? cnt - COUNT_W'(req.spare_in) : '0;
         end else begin
            avail = cnt;
         end
         b0.data = DATA_W'(sum[SEPTET_W-1:0]);
         b0.has  = 1'b1;
         b1.data = DATA_W'(sum[2*SEPTET_W-1:SEPTET_W]);
         b1.has  = 1'b1;
         if (avail >= COUNT_W'(2*SEPTET_W)) begin
            n   = 2'd2;
            sum = '0;
            cnt = cnt - COUNT_W'(2*SEPTET_W);
         end else if (avail >= COUNT_W'(SEPTET_W)) begin
            n   = 2'd1;
            sum = sum >> SEPTET_W;
            cnt = cnt - COUNT_W'(SEPTET_W);
         end
         if (req.last_in) begin
            // drop leftover bits, mark the final beat
            if (n == 2'd2) begin
               b1.last = 1'b1;
            end else if (n == 2'd1) begin
               b0.last = 1'b1;
            end else begin
               b0 = empty_b;
               n  = 2'd1;
            end
            sum = '0;
            cnt = '0;
         end
      end

      push_job.two   = (n == 2'd2);
      push_job.beat0 = b0;
      push_job.beat1 = b1;
      push           = accept && (n != 2'd0);

      mode_in  = mode_ff;
      store_in = store_ff;
      count_in = count_ff;
      if (csr_write_en) begin
         mode_in  = csr_write_data;
         store_in = '0;
         count_in = '0;
      end else if (accept) begin
         store_in = sum;
         count_in = cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PACK;
         store_ff <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         store_ff <= store_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- src/spo_queue.sv -----
// ----------------------------------------------------------------------------
// spo_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module spo_queue
   import spo_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  spo_job_type      push_job,
   input  logic             pop,
   output spo_job_type      head_job,
   output spo_q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   spo_job_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   assign head_job     = slot_ff[rd_ptr_ff];
   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- src/spo_back.sv -----
// ----------------------------------------------------------------------------
// spo_back
// Splits queued jobs into beats and holds them in the output register.
// ----------------------------------------------------------------------------
module spo_back
   import spo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  spo_job_type      head_job,
   input  spo_q_status_type q_status,
   output logic             pop,
   spo_rsp_if.source        rsp
);

   logic         valid_ff, valid_in;
   logic         second_ff, second_in;
   spo_beat_type beat_ff, beat_in;
   logic         load;

   assign load = (!valid_ff || rsp.ready) && !q_status.empty;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      beat_in   = beat_ff;
      pop       = 1'b0;
      if (!valid_ff || rsp.ready) begin
         valid_in = !q_status.empty;
      end
      if (load) begin
         beat_in = second_ff ? head_job.beat1 : head_job.beat0;
         // advance to the next job after its final beat
         pop       = second_ff || !head_job.two;
         second_in = !pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign rsp.valid     = valid_ff;
   assign rsp.data_out  = beat_ff.data;
   assign rsp.has_data  = beat_ff.has;
   assign rsp.last_out  = beat_ff.last;
   assign rsp.spare_out = beat_ff.spare;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for septet_octet_packer_core. It runs a short table of
// directed beats in both directions, then random names in several mode phases,
// and checks every beat against typed table rows or a bit-level predictor.
// ----------------------------------------------------------------------------
module testbench
   import spo_pkg::*;
();

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 8;
   localparam int MAX_GAP        = 12;
   localparam int HOLD_CYCLES    = 100;
   localparam int SETTLE_CYCLES  = 4;
   localparam int IDLE_LIMIT     = 1000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 50;
   localparam int DIRECTED_ROWS  = 24;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct packed {
      logic               mode;
      logic [DATA_W-1:0]  data;
      logic               last;
      logic [SPARE_W-1:0] spare;
      logic               typed;
      logic [1:0]         count;
      spo_beat_type       beat0;
      spo_beat_type       beat1;
   } dir_row_type;

   localparam spo_beat_type NO_BEAT     = '0;
   localparam spo_beat_type PK_7F_END   = '{8'hFE, 1'b1, 1'b1, 3'd1};
   localparam spo_beat_type PK_ZERO_END = '{8'h00, 1'b1, 1'b1, 3'd1};
   localparam spo_beat_type OCT_FF_MID  = '{8'hFF, 1'b1, 1'b0, 3'd0};
   localparam spo_beat_type OCT_FF_END  = '{8'hFF, 1'b1, 1'b1, 3'd0};
   localparam spo_beat_type SEP_7F_MID  = '{8'h7F, 1'b1, 1'b0, 3'd0};
   localparam spo_beat_type SEP_7F_END  = '{8'h7F, 1'b1, 1'b1, 3'd0};
   localparam spo_beat_type EMPTY_END   = '{8'h00, 1'b0, 1'b1, 3'd0};

   localparam dir_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // pack: full septet alone, padded to one octet with one spare bit
      '{MODE_PACK, 8'h7F, 1'b1, 3'd0, 1'b1, 2'd1, PK_7F_END, NO_BEAT},
      // pack: bit 7 of a septet is ignored, and so is spare_in
      '{MODE_PACK, 8'h80, 1'b1, 3'd7, 1'b1, 2'd1, PK_ZERO_END, NO_BEAT},
      // pack: eight ones-septets fill seven octets exactly (aligned end)
      '{MODE_PACK, 8'h7F, 1'b0, 3'd0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
      '{MODE_PACK, 8'h7F, 1'b0, 3'd0, 1'b1, 2'd1, OCT_FF_MID, NO_BEAT},
      '{MODE_PACK, 8'h7F, 1'b0, 3'd0, 1'b1, 2'd1, OCT_FF_MID, NO_BEAT},
      '{MODE_PACK, 8'h7F, 1'b0, 3'd0, 1'b1, 2'd1, OCT_FF_MID, NO_BEAT},
      '{MODE_PACK, 8'h7F, 1'b0, 3'd0, 1'b1, 2'd1, OCT_FF_MID, NO_BEAT},
      '{MODE_PACK, 8'h7F, 1'b0, 3'd0, 1'b1, 2'd1, OCT_FF_MID, NO_BEAT},
      '{MODE_PACK, 8'h7F, 1'b0, 3'd0, 1'b1, 2'd1, OCT_FF_MID, NO_BEAT},
      '{MODE_PACK, 8'h7F, 1'b1, 3'd0, 1'b1, 2'd1, OCT_FF_END, NO_BEAT},
      // pack: mixed bits, left to the predictor
      '{MODE_PACK, 8'h55, 1'b0, 3'd3, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{MODE_PACK, 8'h2A, 1'b1, 3'd5, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      // unpack: lone octet, leftover bit dropped
      '{MODE_UNPACK, 8'hFF, 1'b1, 3'd0, 1'b1, 2'd1, SEP_7F_END, NO_BEAT},
      '{MODE_UNPACK, 8'hFF, 1'b1, 3'd1, 1'b1, 2'd1, SEP_7F_END, NO_BEAT},
      // unpack: padding eats the septet, so an empty closing beat
      '{MODE_UNPACK, 8'h00, 1'b1, 3'd7, 1'b1, 2'd1, EMPTY_END, NO_BEAT},
      // unpack: seven octets give eight septets, two on the last one
      '{MODE_UNPACK, 8'hFF, 1'b0, 3'd0, 1'b1, 2'd1, SEP_7F_MID, NO_BEAT},
      '{MODE_UNPACK, 8'hFF, 1'b0, 3'd0, 1'b1, 2'd1, SEP_7F_MID, NO_BEAT},
      '{MODE_UNPACK, 8'hFF, 1'b0, 3'd0, 1'b1, 2'd1, SEP_7F_MID, NO_BEAT},
      '{MODE_UNPACK, 8'hFF, 1'b0, 3'd0, 1'b1, 2'd1, SEP_7F_MID, NO_BEAT},
      '{MODE_UNPACK, 8'hFF, 1'b0, 3'd0, 1'b1, 2'd1, SEP_7F_MID, NO_BEAT},
      '{MODE_UNPACK, 8'hFF, 1'b0, 3'd0, 1'b1, 2'd1, SEP_7F_MID, NO_BEAT},
      '{MODE_UNPACK, 8'hFF, 1'b1, 3'd0, 1'b1, 2'd2, SEP_7F_MID, SEP_7F_END},
      // unpack: mixed bits with padding, left to the predictor
      '{MODE_UNPACK, 8'hA5, 1'b0, 3'd0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{MODE_UNPACK, 8'h3C, 1'b1, 3'd3, 1'b0, 2'd0, NO_BEAT, NO_BEAT}
   };

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   spo_req_if req_ch ();
   spo_rsp_if rsp_ch ();

   septet_octet_packer_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req            (req_ch),
      .rsp            (rsp_ch)
   );

   // predictor copy of the block's state
   logic               pred_mode;
   logic [STORE_W-1:0] pred_bits;
   logic [COUNT_W-1:0] pred_count;
   spo_beat_type       pred_beat [0:1];
   int                 pred_n;

   // beats still owed by the block, oldest first
   spo_beat_type pending_beats [$];
   int           mismatch_count;

   // idling controls shared by the two sides
   bit req_calm;
   bit rsp_calm;
   bit rsp_hold_req;
   int rsp_stall_left;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic logic [OCTET_W-1:0] flip_octet(input logic [OCTET_W-1:0] v);
      logic [OCTET_W-1:0] r;
      r = {<<{v}};
      return r;
   endfunction

   task automatic add_pred_beat(input logic [DATA_W-1:0] d, input logic has,
                                input logic last, input logic [SPARE_W-1:0] spare);
      pred_beat[pred_n] = '{d, has, last, spare};
      pred_n++;
   endtask

   // Work out the beats that one accepted element causes and advance the
   // accumulator, in the block's current direction.
   task automatic predict_conversion(input logic [DATA_W-1:0] d, input logic last,
                                     input logic [SPARE_W-1:0] spare);
      logic [STORE_W-1:0] incoming;
      int                 avail;
      pred_n = 0;
      if (pred_mode == MODE_PACK) begin
         incoming   = {7'b0, d[SEPTET_W-1:0]};
         pred_bits  = pred_bits | (incoming << pred_count);
         pred_count = pred_count + COUNT_W'(SEPTET_W);
         if (pred_count >= OCTET_W) begin
            add_pred_beat(flip_octet(pred_bits[OCTET_W-1:0]), 1'b1, 1'b0, 3'd0);
            pred_bits  = pred_bits >> OCTET_W;
            pred_count = pred_count - COUNT_W'(OCTET_W);
         end
         if (last) begin
            if (pred_count > 0) begin
               // flush the partial octet, zero padded
               add_pred_beat(flip_octet(pred_bits[OCTET_W-1:0]), 1'b1, 1'b1,
                             SPARE_W'(COUNT_W'(OCTET_W) - pred_count));
            end else if (pred_n > 0) begin
               pred_beat[pred_n-1].last  = 1'b1;
               pred_beat[pred_n-1].spare = 3'd0;
            end else begin
               add_pred_beat(8'h00, 1'b0, 1'b1, 3'd0);
            end
            pred_bits  = '0;
            pred_count = '0;
         end
      end else begin
         incoming   = {6'b0, flip_octet(d)};
         pred_bits  = pred_bits | (incoming << pred_count);
         pred_count = pred_count + COUNT_W'(OCTET_W);
         avail      = int'(pred_count);
         if (last) avail = (int'(spare) <= avail) ? avail - int'(spare) : 0;
         while (avail >= SEPTET_W && pred_n < 2) begin
            add_pred_beat({1'b0, pred_bits[SEPTET_W-1:0]}, 1'b1, 1'b0, 3'd0);
            pred_bits  = pred_bits >> SEPTET_W;
            pred_count = pred_count - COUNT_W'(SEPTET_W);
            avail      = avail - SEPTET_W;
         end
         if (last) begin
            // leftover bits of the name are dropped here
            if (pred_n > 0) pred_beat[pred_n-1].last = 1'b1;
            else add_pred_beat(8'h00, 1'b0, 1'b1, 3'd0);
            pred_bits  = '0;
            pred_count = '0;
         end
      end
   endtask

   // Offer one beat after a random gap and return at the falling edge that
   // follows its accept. Valid is lowered only when a gap is drawn.
   task automatic send_item(input logic [DATA_W-1:0] d, input logic last,
                            input logic [SPARE_W-1:0] spare);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.data_in  <= d;
      req_ch.last_in  <= last;
      req_ch.spare_in <= spare;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   task automatic push_predicted();
      for (int k = 0; k < pred_n; k++) pending_beats.push_back(pred_beat[k]);
   endtask

   // Stop offering, wait until every owed beat has come, then let the
   // block settle: an element that causes no beat may still be in flight.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the direction register; the write also clears the accumulator.
   task automatic write_mode(input logic m);
      drain_results();
      csr_write_data <= m;
      csr_write_en   <= 1'b1;
      @(negedge clock);
      csr_write_en <= 1'b0;
      pred_mode  = m;
      pred_bits  = '0;
      pred_count = '0;
   endtask

   function automatic int draw_name_length();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus: reset, the directed table, then random phases.
   // ---------------------------------------------------------------------
   initial begin
      logic               cur_mode;
      logic [DATA_W-1:0]  d;
      logic               last;
      logic [SPARE_W-1:0] spare;
      int                 name_pos;
      int                 name_len;

      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_write_data  = 1'b0;
      req_ch.valid    = 1'b0;
      req_ch.data_in  = '0;
      req_ch.last_in  = 1'b0;
      req_ch.spare_in = '0;
      req_calm        = 1'b0;
      rsp_calm        = 1'b0;
      rsp_hold_req    = 1'b0;
      mismatch_count  = 0;
      pred_mode       = MODE_PACK;
      pred_bits       = '0;
      pred_count      = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part: write the mode whenever the table switches direction
      cur_mode = DIRECTED[0].mode;
      write_mode(cur_mode);
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].mode != cur_mode) begin
            cur_mode = DIRECTED[r].mode;
            write_mode(cur_mode);
         end
         send_item(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].spare);
         // advance the predictor in any case so its state stays in step
         predict_conversion(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].spare);
         if (DIRECTED[r].typed) begin
            if (DIRECTED[r].count > 0) pending_beats.push_back(DIRECTED[r].beat0);
            if (DIRECTED[r].count > 1) pending_beats.push_back(DIRECTED[r].beat1);
         end else begin
            push_predicted();
         end
      end

      // random part: names of random length, with noise on the last flag;
      // a phase may end mid-name, so the mode write cuts a name short
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 4) write_mode((p % 2 == 0) ? MODE_PACK : MODE_UNPACK);
         else write_mode(logic'($urandom_range(0, 1)));
         // phase 2 runs with no idling at all; phase 3 stalls the result
         // side for a long stretch while the sender keeps offering
         req_calm = (p == 2) || (p == 3) || ($urandom_range(0, 3) == 0);
         rsp_calm = (p == 2) || ($urandom_range(0, 3) == 0);
         if (p == 3) rsp_hold_req = 1'b1;
         name_pos = 0;
         name_len = draw_name_length();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // halfway through phase 5, hold the sender until all beats are in
            if (p == 5 && i == PHASE_ITEMS / 2) drain_results();
            d     = DATA_W'($urandom_range(0, 255));
            spare = SPARE_W'($urandom_range(0, 7));
            last  = (name_pos >= name_len - 1);
            if ($urandom_range(0, 15) == 0) last = ~last;
            if (last) begin
               name_pos = 0;
               name_len = draw_name_length();
            end else begin
               name_pos++;
            end
            send_item(d, last, spare);
            predict_conversion(d, last, spare);
            push_predicted();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: ready follows a per-beat stall count, changed at the
   // falling edge; a hold request stretches one stall.
   // ---------------------------------------------------------------------
   initial begin
      rsp_ch.ready   = 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_stall_left = HOLD_CYCLES;
            rsp_hold_req   = 1'b0;
         end
         if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Check each accepted beat against the oldest owed beat, then draw the
   // stall before the next one.
   always @(posedge clock) begin
      spo_beat_type got;
      spo_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.data_out, rsp_ch.has_data, rsp_ch.last_out, rsp_ch.spare_out};
         if (pending_beats.size() == 0) begin
            $error("unexpected beat: data_out %0h has_data %0b last_out %0b spare_out %0d",
                   got.data, got.has, got.last, got.spare);
            mismatch_count++;
         end else begin
            want = pending_beats.pop_front();
            if (got.data !== want.data) begin
               $error("data_out: expected %0h, got %0h", want.data, got.data);
               mismatch_count++;
            end
            if (got.has !== want.has) begin
               $error("has_data: expected %0b, got %0b", want.has, got.has);
               mismatch_count++;
            end
            if (got.last !== want.last) begin
               $error("last_out: expected %0b, got %0b", want.last, got.last);
               mismatch_count++;
            end
            if (got.spare !== want.spare) begin
               $error("spare_out: expected %0d, got %0d", want.spare, got.spare);
               mismatch_count++;
            end
         end
         rsp_stall_left = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run when no beat moves on either side for too long.
   // ---------------------------------------------------------------------
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
